// ===== hdl/go_back_n_sender_defines.svh =====
// ---------------------------------------------------------------------------
// Go-Back-N sender assertion macros
// Shared property wrappers, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_DEFINES_SVH
`define GO_BACK_N_SENDER_DEFINES_SVH

// same-cycle implication
`define GBN_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gbn_pkg.sv =====
// ---------------------------------------------------------------------------
// Go-Back-N sender package
// Packet record type, event and timer codes, fixed sizes.
// ---------------------------------------------------------------------------
package gbn_pkg;

  localparam int PAYLOAD_BYTES = 20;

  localparam logic [1:0] ACT_MSG     = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  localparam logic [6:0] WINDOW_MAX = 7'd64;
  localparam logic [6:0] RESEND_MAX = 7'd64;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] mid;
    logic [31:0] high;
    logic [31:0] check;
  } pkt_t;

endpackage

// ===== hdl/gbn_pkt_buf.sv =====
// ---------------------------------------------------------------------------
// Go-Back-N packet buffer
// One write port and one registered read port over the retransmit store.
// ---------------------------------------------------------------------------
module gbn_pkt_buf import gbn_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pkt_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output pkt_t          rd_data
);

  pkt_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/go_back_n_sender.sv =====
// ---------------------------------------------------------------------------
// Go-Back-N sender
// Sequence numbering, checksum, retransmit buffer and window control.
// ---------------------------------------------------------------------------
// Usage: raise start with an event (action plus fields) while busy is low;
// the beat is taken at that edge and busy stays high until the last result
// is out. Results appear on the result ports for one cycle each, marked by
// result_strobe; the receiver cannot stall, so they are never held.
// The checksum is built by one 32-bit adder, one byte or word per cycle.
// Message: the adder takes the 20 payload bytes and the new sequence number,
// then buffer write, window check and output steps. Ack: the adder takes
// the 20 payload bytes, ack number and ack sequence, then a compare; an
// accepted ack then walks the buffer index over each sequence number the
// window base advances (up to 64). Timeout: a buffer read then output per
// resent packet, up to 64 packets; one result when nothing is outstanding.
// The user is to write window_size over the cfg channel only while the block is idle; the block does not enforce this.
// Reset clears the sequence counters and sets window_size to 8; the buffer
// holds no reset value and is only read at entries already written.
// ---------------------------------------------------------------------------
`include "go_back_n_sender_defines.svh"

module go_back_n_sender import gbn_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [63:0]        payload_low,
  input  logic [63:0]        payload_mid,
  input  logic [31:0]        payload_high,
  input  logic signed [31:0] ack_sequence,
  input  logic signed [31:0] ack_number,
  input  logic signed [31:0] ack_check,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  output logic               result_strobe,
  output logic               packet_valid,
  output logic [30:0]        packet_sequence,
  output logic signed [31:0] packet_check,
  output logic [63:0]        out_payload_low,
  output logic [63:0]        out_payload_mid,
  output logic [31:0]        out_payload_high,
  output logic [1:0]         timer_command,
  output logic               message_dropped,
  output logic               last_result
);

  localparam int IW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(BUFFER_DEPTH - 1);
  localparam logic [31:0] DEPTH_W = 32'(BUFFER_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_MSG   = 4'd2;
  localparam logic [3:0] S_MSEL  = 4'd3;
  localparam logic [3:0] S_MOUT  = 4'd4;
  localparam logic [3:0] S_ACK   = 4'd5;
  localparam logic [3:0] S_ASTEP = 4'd6;
  localparam logic [3:0] S_TRD   = 4'd7;
  localparam logic [3:0] S_TOUT  = 4'd8;
  localparam logic [3:0] S_NULL  = 4'd9;

  logic [3:0]  state;
  logic [6:0]  window_size;
  logic [1:0]  act;
  logic [PAYLOAD_BYTES-1:0][7:0] pay;
  logic [31:0] ack_seq_q;
  logic [31:0] ack_num_q;
  logic [31:0] ack_chk_q;
  logic [31:0] acc;
  logic [6:0]  cnt;
  logic [31:0] window_base;
  logic [31:0] next_to_send;
  logic [31:0] next_new;
  logic [IW-1:0] base_idx;
  logic [IW-1:0] send_idx;
  logic [IW-1:0] new_idx;
  logic [IW-1:0] walk_idx;
  logic [31:0] walk_seq;
  logic [1:0]  tcmd;
  logic        dropped;

  logic [31:0] operand;
  logic [6:0]  eff_win;
  logic        full;
  logic        send_ok;
  logic [31:0] nb;
  logic        ack_ok;
  logic [31:0] outstanding;
  logic        accept;
  logic        emit_pkt;
  logic        emit_null;
  logic [31:0] emit_seq;
  logic        emit_last;
  logic        wr_en;
  pkt_t        wr_data;
  logic [IW-1:0] rd_addr;
  pkt_t        rd_data;

  // index of seq+1, given the index of seq; the 32-bit wrap restarts at zero
  function automatic logic [IW-1:0] idx_step(input logic [31:0] seq,
                                             input logic [IW-1:0] idx);
    logic [IW-1:0] r;
    if (seq == 32'hFFFF_FFFF || idx == IDX_LAST) begin
      r = '0;
    end else begin
      r = idx + IW'(1);
    end
    return r;
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    if (cnt < 7'(PAYLOAD_BYTES)) begin
      operand = {{24{pay[cnt[4:0]][7]}}, pay[cnt[4:0]]};
    end else if (cnt == 7'(PAYLOAD_BYTES)) begin
      operand = (act == ACT_MSG) ? next_new : ack_num_q;
    end else begin
      operand = ack_seq_q;
    end
  end

  always_comb begin
    if (window_size == 7'd0) begin
      eff_win = 7'd1;
    end else if (window_size > WINDOW_MAX) begin
      eff_win = WINDOW_MAX;
    end else begin
      eff_win = window_size;
    end
  end

  assign full        = (next_new - window_base) >= DEPTH_W;
  assign send_ok     = (next_to_send != next_new) &&
                       ((next_to_send - window_base) < {25'd0, eff_win});
  assign nb          = ack_num_q + 32'd1;
  assign ack_ok      = (acc == ack_chk_q) &&
                       ((nb - window_base) <= (next_to_send - window_base));
  assign outstanding = next_to_send - window_base;

  assign emit_pkt  = (state == S_MOUT) || (state == S_TOUT);
  assign emit_null = (state == S_NULL);
  assign emit_seq  = (state == S_TOUT) ? walk_seq : next_to_send;
  assign emit_last = (state == S_TOUT) ? (cnt == 7'd1) : 1'b1;

  assign wr_en         = (state == S_MSG) && !full;
  assign wr_data.low   = pay[7:0];
  assign wr_data.mid   = pay[15:8];
  assign wr_data.high  = pay[19:16];
  assign wr_data.check = acc;
  assign rd_addr       = (state == S_TRD) ? walk_idx : send_idx;

  gbn_pkt_buf #(
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (new_idx),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_size   <= 7'd8;
      cnt           <= '0;
      window_base   <= '0;
      next_to_send  <= '0;
      next_new      <= '0;
      base_idx      <= '0;
      send_idx      <= '0;
      new_idx       <= '0;
      walk_idx      <= '0;
      walk_seq      <= '0;
      tcmd          <= TMR_NONE;
      dropped       <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit_pkt || emit_null;
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            dropped <= 1'b0;
            case (action)
              ACT_MSG, ACT_ACK: begin
                cnt   <= '0;
                tcmd  <= TMR_NONE;
                state <= S_SUM;
              end
              ACT_TIMEOUT: begin
                tcmd     <= TMR_START;
                walk_seq <= window_base;
                walk_idx <= base_idx;
                cnt      <= (outstanding > {25'd0, RESEND_MAX}) ? RESEND_MAX
                                                                : outstanding[6:0];
                state    <= (outstanding == 32'd0) ? S_NULL : S_TRD;
              end
              default: begin
                tcmd  <= TMR_NONE;
                state <= S_NULL;
              end
            endcase
          end
        end
        S_SUM: begin
          cnt <= cnt + 7'd1;
          if (act == ACT_MSG && cnt == 7'(PAYLOAD_BYTES)) begin
            state <= S_MSG;
          end else if (cnt == 7'(PAYLOAD_BYTES + 1)) begin
            state <= S_ACK;
          end
        end
        S_MSG: begin
          if (full) begin
            dropped <= 1'b1;
          end else begin
            next_new <= next_new + 32'd1;
            new_idx  <= idx_step(next_new, new_idx);
          end
          state <= S_MSEL;
        end
        S_MSEL: begin
          if (send_ok) begin
            tcmd  <= (window_base == next_to_send) ? TMR_START : TMR_NONE;
            state <= S_MOUT;
          end else begin
            state <= S_NULL;
          end
        end
        S_MOUT: begin
          next_to_send <= next_to_send + 32'd1;
          send_idx     <= idx_step(next_to_send, send_idx);
          state        <= S_IDLE;
        end
        S_ACK: begin
          if (ack_ok) begin
            cnt         <= 7'(nb - window_base);
            walk_seq    <= window_base;
            walk_idx    <= base_idx;
            window_base <= nb;
            tcmd        <= (nb == next_to_send) ? TMR_STOP : TMR_START;
            state       <= S_ASTEP;
          end else begin
            state <= S_NULL;
          end
        end
        S_ASTEP: begin
          // walk the base index forward one sequence number a cycle
          if (cnt == 7'd0) begin
            base_idx <= walk_idx;
            state    <= S_NULL;
          end else begin
            walk_idx <= idx_step(walk_seq, walk_idx);
            walk_seq <= walk_seq + 32'd1;
            cnt      <= cnt - 7'd1;
          end
        end
        S_TRD: begin
          state <= S_TOUT;
        end
        S_TOUT: begin
          tcmd     <= TMR_NONE;
          walk_idx <= idx_step(walk_seq, walk_idx);
          walk_seq <= walk_seq + 32'd1;
          cnt      <= cnt - 7'd1;
          state    <= (cnt == 7'd1) ? S_IDLE : S_TRD;
        end
        S_NULL: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // event capture, checksum adder and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act       <= action;
      pay[7:0]  <= payload_low;
      pay[15:8] <= payload_mid;
      pay[19:16] <= payload_high;
      ack_seq_q <= 32'(ack_sequence);
      ack_num_q <= 32'(ack_number);
      ack_chk_q <= 32'(ack_check);
      acc       <= '0;
    end else if (state == S_SUM) begin
      acc <= acc + operand;
    end
    if (emit_pkt) begin
      packet_valid     <= 1'b1;
      packet_sequence  <= emit_seq[30:0];
      packet_check     <= signed'(rd_data.check);
      out_payload_low  <= rd_data.low;
      out_payload_mid  <= rd_data.mid;
      out_payload_high <= rd_data.high;
    end else if (emit_null) begin
      packet_valid     <= 1'b0;
      packet_sequence  <= '0;
      packet_check     <= '0;
      out_payload_low  <= '0;
      out_payload_mid  <= '0;
      out_payload_high <= '0;
    end
    if (emit_pkt || emit_null) begin
      timer_command   <= tcmd;
      message_dropped <= dropped;
      last_result     <= emit_last;
    end
  end

  `GBN_ASSERT(a_more_results_busy, result_strobe && !last_result, busy, "result run ended early")
  `GBN_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `GBN_ASSERT(a_window_bound, 1'b1, (next_to_send - window_base) <= 32'd64, "window overrun")
  `GBN_ASSERT(a_buffer_bound, 1'b1, (next_new - window_base) <= DEPTH_W, "buffer overrun")
  `GBN_ASSERT(a_send_behind_new, 1'b1,
    (next_to_send - window_base) <= (next_new - window_base), "sent past newest message")

endmodule
